// ----- src/spc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere/plane contact resolver package
// Shared types, stage map and arithmetic helpers for the contact pipeline.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X    = 3'd0,
        REG_NORMAL_Y    = 3'd1,
        REG_NORMAL_Z    = 3'd2,
        REG_OFFSET      = 3'd3,
        REG_RESTITUTION = 3'd4,
        REG_FRICTION    = 3'd5,
        REG_MIN_BOUNCE  = 3'd6,
        REG_GRAVITY     = 3'd7
    } spc_reg_t;

    typedef struct packed {
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic signed [31:0] off;
        logic        [16:0] prest;
        logic        [18:0] pfric;
        logic        [30:0] minb;
        logic        [30:0] gstep;
    } spc_cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] sphere_radius;
        logic        [30:0] sphere_mass;
        logic        [16:0] body_restitution;
        logic        [18:0] body_friction;
    } spc_in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] spin_change_x;
        logic signed [31:0] spin_change_y;
        logic signed [31:0] spin_change_z;
        logic               in_contact;
    } spc_out_t;

    typedef struct packed {
        logic                contact;
        logic [2:0][31:0]    p;
        logic [2:0][31:0]    v;
        logic [2:0][31:0]    vt;
        logic [2:0][63:0]    pa;
        logic [2:0][63:0]    pb;
        logic [63:0]         fp;
        logic [30:0]         r;
        logic [16:0]         br;
        logic [18:0]         bf;
        logic signed [32:0]  rsum;
        logic signed [39:0]  gap;
        logic signed [39:0]  vn;
        logic [63:0]         jp;
        logic                neg;
        logic                big;
        logic [37:0]         jn;
        logic [63:0]         srad;
        logic [33:0]         srem;
        logic [31:0]         sroot;
        logic [33:0]         mrem;
        logic [31:0]         mroot;
        logic [63:0]         fa;
        logic [63:0]         fb;
        logic [31:0]         total;
        logic [2:0][32:0]    drem;
        logic [2:0][31:0]    dq;
        logic [32:0]         den;
        logic [2:0]          ovf;
        logic [2:0]          sneg;
    } spc_item_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } spc_sq_t;

    typedef struct packed {
        logic [32:0] rem;
        logic        q;
    } spc_dv_t;

    localparam int SQ_STAGES = 16;
    localparam int DV_STAGES = 16;

    localparam int S_DOT  = 0;
    localparam int S_DIST = 1;
    localparam int S_PEN  = 2;
    localparam int S_NPOS = 3;
    localparam int S_JN   = 4;
    localparam int S_V1   = 5;
    localparam int S_V1N  = 6;
    localparam int S_VN1  = 7;
    localparam int S_VN1N = 8;
    localparam int S_VT   = 9;
    localparam int S_SQR  = 10;
    localparam int S_SUM  = 11;
    localparam int S_SQ0  = 12;
    localparam int S_FMUL = S_SQ0 + SQ_STAGES;
    localparam int S_FRIC = S_FMUL + 1;
    localparam int S_DMUL = S_FRIC + 1;
    localparam int S_DV0  = S_DMUL + 1;
    localparam int S_DAPP = S_DV0 + DV_STAGES;
    localparam int S_SMUL = S_DAPP + 1;
    localparam int S_SNUM = S_SMUL + 1;
    localparam int S_SDEN = S_SNUM + 1;
    localparam int S_SV0  = S_SDEN + 1;
    localparam int S_SPIN = S_SV0 + DV_STAGES;
    localparam int NST    = S_SPIN + 1;

    function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + 64'sd32768;
        return $signed(t[63:16]);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic spc_sq_t sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                          input logic [1:0] bits);
        logic [35:0] r2;
        logic [35:0] trial;
        logic [35:0] diff;
        spc_sq_t     o;
        r2    = {rem, bits};
        trial = {2'b00, root, 2'b01};
        diff  = r2 - trial;
        if (r2 >= trial)
        begin
            o.rem  = diff[33:0];
            o.root = {root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = r2[33:0];
            o.root = {root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic spc_dv_t div_step(input logic [32:0] rem, input logic b,
                                         input logic [32:0] den);
        logic [33:0] r2;
        logic [33:0] dd;
        logic [33:0] diff;
        spc_dv_t     o;
        r2   = {rem, b};
        dd   = {1'b0, den};
        diff = r2 - dd;
        if (r2 >= dd)
        begin
            o.rem = diff[32:0];
            o.q   = 1'b1;
        end
        else
        begin
            o.rem = r2[32:0];
            o.q   = 1'b0;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ----- src/spc_pipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Contact pipeline
// Stage array for gap test, push-out, normal impulse, friction and spin.
// ----------------------------------------------------------------------------
module spc_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               item_valid,
    input  spc_pkg::spc_in_t   item,
    input  spc_pkg::spc_cfg_t  cfg,
    output logic               result_valid,
    output spc_pkg::spc_out_t  result
);

    spc_pkg::spc_item_t               stage_reg  [spc_pkg::NST];
    spc_pkg::spc_item_t               stage_next [spc_pkg::NST];
    logic [spc_pkg::NST-1:0]          valid_reg;
    spc_pkg::spc_item_t               load;

    function automatic spc_pkg::spc_item_t stage_op(input int k, input spc_pkg::spc_item_t a,
                                                    input spc_pkg::spc_cfg_t c);
        spc_pkg::spc_item_t o;
        logic signed [63:0] nn [3];
        logic signed [63:0] t;
        logic signed [63:0] dw;
        logic signed [63:0] d;
        logic [16:0]        e;
        logic [17:0]        fac;
        logic [63:0]        fric;
        logic [31:0]        mag;
        logic [30:0]        rr;
        spc_pkg::spc_sq_t   sq;
        spc_pkg::spc_dv_t   ds;
        o     = a;
        nn[0] = 64'(c.nx);
        nn[1] = 64'(c.ny);
        nn[2] = 64'(c.nz);
        unique case (k) inside
            spc_pkg::S_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    o.pa[i] = 64'(64'($signed(a.p[i])) * nn[i]);
                    o.pb[i] = 64'(64'($signed(a.v[i])) * nn[i]);
                end
                o.fp   = 64'(a.bf) * 64'(c.pfric);
                o.rsum = 33'(c.off) + $signed({2'b00, a.r});
            end
            spc_pkg::S_DIST:
            begin
                dw = $signed(a.pa[0]) + $signed(a.pa[1]) + $signed(a.pa[2])
                   - (64'(a.rsum) <<< 16);
                o.contact = dw[63];
                t         = dw >>> 16;
                o.gap     = t[39:0];
                t         = 64'(spc_pkg::rnd16($signed(a.pb[0]) + $signed(a.pb[1])
                                               + $signed(a.pb[2])));
                o.vn      = t[39:0];
            end
            spc_pkg::S_PEN:
            begin
                for (int i = 0; i < 3; i++)
                    o.pa[i] = 64'(nn[i] * 64'(a.gap));
                e     = (a.br < c.prest) ? a.br : c.prest;
                fac   = 18'd65536 + 18'(e);
                o.jp  = 64'(64'(fac) * (-64'(a.vn)));
                o.neg = a.vn[39];
                o.big = (-64'(a.vn)) > $signed({33'd0, c.minb});
            end
            spc_pkg::S_NPOS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t = (64'($signed(a.p[i])) <<< 16) - $signed(a.pa[i]);
                    if (a.contact)
                        o.p[i] = spc_pkg::sat32(64'(spc_pkg::rnd16(t)));
                end
                t = -64'(a.vn);
                if (!a.neg)
                    o.jn = '0;
                else if (a.big)
                begin
                    t    = 64'(spc_pkg::rnd16($signed(a.jp)));
                    o.jn = t[37:0];
                end
                else
                    o.jn = t[37:0];
            end
            spc_pkg::S_JN:
            begin
                for (int i = 0; i < 3; i++)
                    o.pb[i] = 64'($signed({26'd0, a.jn}) * nn[i]);
            end
            spc_pkg::S_V1:
            begin
                for (int i = 0; i < 3; i++)
                    if (a.contact)
                        o.v[i] = spc_pkg::sat32(64'($signed(a.v[i]))
                                 + 64'(spc_pkg::rnd16($signed(a.pb[i]))));
            end
            spc_pkg::S_V1N:
            begin
                for (int i = 0; i < 3; i++)
                    o.pb[i] = 64'(64'($signed(a.v[i])) * nn[i]);
            end
            spc_pkg::S_VN1:
            begin
                t      = 64'(spc_pkg::rnd16($signed(a.pb[0]) + $signed(a.pb[1])
                                            + $signed(a.pb[2])));
                o.gap  = t[39:0];
            end
            spc_pkg::S_VN1N:
            begin
                for (int i = 0; i < 3; i++)
                    o.pb[i] = 64'(64'(a.gap) * nn[i]);
            end
            spc_pkg::S_VT:
            begin
                for (int i = 0; i < 3; i++)
                    o.vt[i] = spc_pkg::sat32(64'($signed(a.v[i]))
                              - 64'(spc_pkg::rnd16($signed(a.pb[i]))));
            end
            spc_pkg::S_SQR:
            begin
                for (int i = 0; i < 3; i++)
                    o.pb[i] = 64'(64'($signed(a.vt[i])) * 64'($signed(a.vt[i])));
            end
            spc_pkg::S_SUM:
            begin
                o.srad  = a.pb[0] + a.pb[1] + a.pb[2];
                o.srem  = '0;
                o.sroot = '0;
                o.mrem  = '0;
                o.mroot = '0;
            end
            [spc_pkg::S_SQ0 : spc_pkg::S_SQ0 + spc_pkg::SQ_STAGES - 1]:
            begin
                for (int j = 0; j < 2; j++)
                begin
                    sq      = spc_pkg::sqrt_step(o.srem, o.sroot, o.srad[63:62]);
                    o.srem  = sq.rem;
                    o.sroot = sq.root;
                    o.srad  = {o.srad[61:0], 2'b00};
                    sq      = spc_pkg::sqrt_step(o.mrem, o.mroot, o.fp[63:62]);
                    o.mrem  = sq.rem;
                    o.mroot = sq.root;
                    o.fp    = {o.fp[61:0], 2'b00};
                end
            end
            spc_pkg::S_FMUL:
            begin
                o.fa = 64'(a.mroot) * 64'(a.jn);
                o.fb = 64'(a.mroot) * 64'(c.gstep);
            end
            spc_pkg::S_FRIC:
            begin
                fric    = (a.fa >> 16) + (a.fb >> 16);
                o.total = (fric < 64'(a.sroot)) ? fric[31:0] : a.sroot;
            end
            spc_pkg::S_DMUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag       = a.vt[i][31] ? -a.vt[i] : a.vt[i];
                    o.pb[i]   = 64'(a.total) * 64'(mag);
                    o.drem[i] = {1'b0, o.pb[i][63:32]};
                    o.dq[i]   = '0;
                end
                o.den = {1'b0, a.sroot};
            end
            [spc_pkg::S_DV0 : spc_pkg::S_DV0 + spc_pkg::DV_STAGES - 1],
            [spc_pkg::S_SV0 : spc_pkg::S_SV0 + spc_pkg::DV_STAGES - 1]:
            begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 2; j++)
                    begin
                        ds        = spc_pkg::div_step(o.drem[i], o.pb[i][31], o.den);
                        o.drem[i] = ds.rem;
                        o.dq[i]   = {o.dq[i][30:0], ds.q};
                        o.pb[i]   = {o.pb[i][62:0], 1'b0};
                    end
            end
            spc_pkg::S_DAPP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (a.contact && (a.sroot != '0))
                        d = a.vt[i][31] ? -64'(a.dq[i]) : 64'(a.dq[i]);
                    else
                        d = '0;
                    o.vt[i] = d[31:0];
                    o.v[i]  = spc_pkg::sat32(64'($signed(a.v[i])) - d);
                end
            end
            spc_pkg::S_SMUL:
            begin
                o.pa[0] = 64'(nn[1] * 64'($signed(a.vt[2])));
                o.pb[0] = 64'(nn[2] * 64'($signed(a.vt[1])));
                o.pa[1] = 64'(nn[2] * 64'($signed(a.vt[0])));
                o.pb[1] = 64'(nn[0] * 64'($signed(a.vt[2])));
                o.pa[2] = 64'(nn[0] * 64'($signed(a.vt[1])));
                o.pb[2] = 64'(nn[1] * 64'($signed(a.vt[0])));
            end
            spc_pkg::S_SNUM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t         = $signed(a.pa[i]) - $signed(a.pb[i]);
                    t         = (t <<< 2) + t;
                    o.sneg[i] = t[63];
                    o.pb[i]   = t[63] ? 64'(-t) : 64'(t);
                end
            end
            spc_pkg::S_SDEN:
            begin
                rr    = (a.r == '0) ? 31'd1 : a.r;
                o.den = {1'b0, rr, 1'b0};
                for (int i = 0; i < 3; i++)
                begin
                    o.ovf[i]  = (a.pb[i] >> 31) >= 64'(o.den);
                    o.drem[i] = o.ovf[i] ? 33'd0 : {1'b0, a.pb[i][63:32]};
                    o.dq[i]   = '0;
                end
            end
            spc_pkg::S_SPIN:
            begin
                for (int i = 0; i < 3; i++)
                    if (a.ovf[i])
                        o.vt[i] = a.sneg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    else
                        o.vt[i] = a.sneg[i] ? -a.dq[i] : a.dq[i];
            end
            default:
            begin
                o = a;
            end
        endcase
        return o;
    endfunction

    always_comb
    begin
        load      = '0;
        load.p[0] = item.pos_x;
        load.p[1] = item.pos_y;
        load.p[2] = item.pos_z;
        load.v[0] = item.vel_x;
        load.v[1] = item.vel_y;
        load.v[2] = item.vel_z;
        load.r    = item.sphere_radius;
        load.br   = item.body_restitution;
        load.bf   = item.body_friction;
        stage_next[0] = stage_op(0, load, cfg);
        for (int k = 1; k < spc_pkg::NST; k++)
            stage_next[k] = stage_op(k, stage_reg[k-1], cfg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[spc_pkg::NST-2:0], item_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    always_comb
    begin
        result_valid         = valid_reg[spc_pkg::NST-1];
        result.new_pos_x     = stage_reg[spc_pkg::NST-1].p[0];
        result.new_pos_y     = stage_reg[spc_pkg::NST-1].p[1];
        result.new_pos_z     = stage_reg[spc_pkg::NST-1].p[2];
        result.new_vel_x     = stage_reg[spc_pkg::NST-1].v[0];
        result.new_vel_y     = stage_reg[spc_pkg::NST-1].v[1];
        result.new_vel_z     = stage_reg[spc_pkg::NST-1].v[2];
        result.spin_change_x = stage_reg[spc_pkg::NST-1].vt[0];
        result.spin_change_y = stage_reg[spc_pkg::NST-1].vt[1];
        result.spin_change_z = stage_reg[spc_pkg::NST-1].vt[2];
        result.in_contact    = stage_reg[spc_pkg::NST-1].contact;
    end

endmodule
`default_nettype wire

// ----- src/sphere_plane_contact_resolver_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere/plane contact resolver
// Resolves one sphere per transfer against the configured plane.
//
//   channel   signals                              direction
//   item      item_valid, item_ready, item         in
//   result    result_valid, result_ready, result   out
//   config    cfg_we, cfg_index, cfg_data          in
//
// One transfer per cycle when no result waits; stages include the 16-stage
// square root and two 16-stage long divisions (two quotient bits per stage).
// Reset clears all stage valid bits and loads the plane register defaults.
// A waiting result holds every stage; item_ready = !result_valid || result_ready.
// ----------------------------------------------------------------------------
module sphere_plane_contact_resolver_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  spc_pkg::spc_in_t                 item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output spc_pkg::spc_out_t                result,
    input  logic                             cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    spc_pkg::spc_cfg_t cfg_reg;
    logic              adv;

    assign adv        = !result_valid || result_ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nx    <= 18'sd0;
            cfg_reg.ny    <= 18'sd65536;
            cfg_reg.nz    <= 18'sd0;
            cfg_reg.off   <= 32'sd0;
            cfg_reg.prest <= 17'd32768;
            cfg_reg.pfric <= 19'd32768;
            cfg_reg.minb  <= 31'd32768;
            cfg_reg.gstep <= 31'd10715;
        end
        else if (cfg_we)
        begin
            unique case (spc_pkg::spc_reg_t'(cfg_index))
                spc_pkg::REG_NORMAL_X:    cfg_reg.nx    <= $signed(cfg_data[17:0]);
                spc_pkg::REG_NORMAL_Y:    cfg_reg.ny    <= $signed(cfg_data[17:0]);
                spc_pkg::REG_NORMAL_Z:    cfg_reg.nz    <= $signed(cfg_data[17:0]);
                spc_pkg::REG_OFFSET:      cfg_reg.off   <= $signed(cfg_data);
                spc_pkg::REG_RESTITUTION: cfg_reg.prest <= cfg_data[16:0];
                spc_pkg::REG_FRICTION:    cfg_reg.pfric <= cfg_data[18:0];
                spc_pkg::REG_MIN_BOUNCE:  cfg_reg.minb  <= cfg_data[30:0];
                spc_pkg::REG_GRAVITY:     cfg_reg.gstep <= cfg_data[30:0];
            endcase
        end
    end

    spc_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (item_valid),
        .item         (item),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- src/spc_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Contact resolver port checker
// Port-level checks on the resolver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spc_check (
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input spc_pkg::spc_out_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("stalled result changed");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready == (!result_valid || result_ready))
        else $error("item_ready out of step with the output stage");

    a_no_contact_spin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.in_contact |->
            result.spin_change_x == 32'sd0 && result.spin_change_y == 32'sd0 &&
            result.spin_change_z == 32'sd0)
        else $error("spin change without contact");

endmodule

bind sphere_plane_contact_resolver_top spc_check u_check (.*);
`default_nettype wire
